/* hdl/aes_pkg.sv */
`default_nettype none

package aes_pkg;

  localparam int Rounds   = 10;
  localparam int KeyWords = 44;

  localparam logic [3:0] LastRound = 4'(Rounds);
  localparam logic [5:0] LastWord  = 6'(KeyWords - 1);

  typedef enum logic [2:0] {
    CFG_KEY_HIGH   = 3'd0,
    CFG_KEY_LOW    = 3'd1,
    CFG_IV_HIGH    = 3'd2,
    CFG_IV_LOW     = 3'd3,
    CFG_CHAIN_MODE = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_e;

  typedef logic [7:0] byte_tab_t [256];

  function automatic logic [7:0] xtime(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h00;
    p = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ p;
      p = xtime(p);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] b, int n);
    return 8'((b << n) | (b >> (8 - n)));
  endfunction

  // Affine map applied to the inverse as x^254 in GF(2^8); evaluated at elaboration.
  function automatic byte_tab_t gen_sbox();
    byte_tab_t  tab;
    logic [7:0] r;
    logic [7:0] p;
    logic [7:0] e;
    for (int x = 0; x < 256; x++) begin
      r = 8'h01;
      p = x[7:0];
      e = 8'd254;
      for (int k = 0; k < 8; k++) begin
        if (e[k]) r = gmul(r, p);
        p = gmul(p, p);
      end
      tab[x] = r ^ rotl8(r, 1) ^ rotl8(r, 2) ^ rotl8(r, 3) ^ rotl8(r, 4) ^ 8'h63;
    end
    return tab;
  endfunction

  function automatic byte_tab_t gen_inv_sbox();
    byte_tab_t fwd;
    byte_tab_t tab;
    fwd = gen_sbox();
    for (int x = 0; x < 256; x++) begin
      tab[fwd[x]] = x[7:0];
    end
    return tab;
  endfunction

  localparam byte_tab_t SBOX     = gen_sbox();
  localparam byte_tab_t INV_SBOX = gen_inv_sbox();

  // Byte k of the state sits in bits 127-8k down to 120-8k.
  function automatic logic [127:0] shift_rows(logic [127:0] s, logic inv);
    logic [127:0] t;
    int src;
    int dst;
    t = '0;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (inv) begin
          src = r + 4 * c;
          dst = r + 4 * ((c + r) % 4);
        end else begin
          src = r + 4 * ((c + r) % 4);
          dst = r + 4 * c;
        end
        t[127 - 8 * dst -: 8] = s[127 - 8 * src -: 8];
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] mix_col(logic [31:0] a, logic inv);
    logic [7:0]  m [4];
    logic [7:0]  v;
    logic [31:0] o;
    if (inv) begin
      m[0] = 8'h0e; m[1] = 8'h0b; m[2] = 8'h0d; m[3] = 8'h09;
    end else begin
      m[0] = 8'h02; m[1] = 8'h03; m[2] = 8'h01; m[3] = 8'h01;
    end
    o = '0;
    for (int r = 0; r < 4; r++) begin
      v = 8'h00;
      for (int k = 0; k < 4; k++) begin
        v = v ^ gmul(m[(k - r + 4) % 4], a[31 - 8 * k -: 8]);
      end
      o[31 - 8 * r -: 8] = v;
    end
    return o;
  endfunction

endpackage

`default_nettype wire

/* hdl/aes_in_if.sv */
`default_nettype none

interface aes_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic        first_block;
  logic [63:0] block_in_high;
  logic [63:0] block_in_low;

  modport source (output valid, output opcode, output first_block,
                  output block_in_high, output block_in_low, input ready);
  modport sink   (input valid, input opcode, input first_block,
                  input block_in_high, input block_in_low, output ready);
endinterface

`default_nettype wire

/* hdl/aes_out_if.sv */
`default_nettype none

interface aes_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_out_high;
  logic [63:0] block_out_low;

  modport source (output valid, output block_out_high, output block_out_low, input ready);
  modport sink   (input valid, input block_out_high, input block_out_low, output ready);
endinterface

`default_nettype wire

/* hdl/aes128_cbc_ecb_cipher.sv */
// AES-128 block cipher, CBC or ECB, one 16-byte block per beat.
// Input channel in_i carries the opcode (encrypt/decrypt), the first-block
// flag and the block; output channel out_o returns one result block per
// input beat, in order. Key, IV and chain mode are written through the plain
// write port (cfg_we_i, cfg_idx_i, cfg_data_i); the user must do so only while the
// block is idle, which the block itself does not enforce. The datapath is byte serial:
// SubBytes works through the 16 bytes one at a time, MixColumns and AddRoundKey one
// column per cycle, ShiftRows on the whole state at once. A block passes through the
// round sequencer and then write-back; a new block is accepted only back in idle.
// Round keys live in a 44-word memory filled one word per cycle; after reset
// and after every key write the schedule is rebuilt, and in_i.ready stays low
// until the last word is written.
// Results wait in an output register; when the receiver stalls, the finished
// block holds there and a new block may already be accepted and processed,
// but its write-back waits until the output register is free.
// Reset clears key, IV and chain to zero and selects CBC mode.
`default_nettype none

module aes128_cbc_ecb_cipher
  import aes_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  aes_in_if.sink           in_i,
  aes_out_if.source        out_o
);

  typedef enum logic [4:0] {
    S_KLOAD  = 5'b00001,
    S_EXPAND = 5'b00010,
    S_IDLE   = 5'b00100,
    S_RUN    = 5'b01000,
    S_WB     = 5'b10000
  } state_e;

  typedef enum logic [3:0] {
    P_ARK = 4'b0001,
    P_SUB = 4'b0010,
    P_SR  = 4'b0100,
    P_MIX = 4'b1000
  } phase_e;

  state_e       state_q, state_d;
  phase_e       phase_q, phase_d;
  logic [3:0]   cnt_q, cnt_d;
  logic [3:0]   kidx_q, kidx_d;
  logic         dec_q;
  logic [63:0]  key_high_q, key_low_q, iv_high_q, iv_low_q;
  logic         cbc_q;
  logic [63:0]  chain_high_q, chain_low_q;
  logic [127:0] win_q;
  logic [7:0]   rcon_q;
  logic [5:0]   exp_cnt_q;
  logic [127:0] st_q, st_d;
  logic [127:0] prev_q;
  logic [127:0] res_q;
  logic         out_vld_q;
  logic [31:0]  rk_q;
  logic [31:0]  rk_mem [KeyWords];

  logic         in_acc;
  logic         wb_go;
  logic         key_wr;
  logic [127:0] prev_sel;
  logic [127:0] in_blk;
  logic [31:0]  exp_t, exp_f, exp_new, exp_wdata;
  logic [5:0]   rd_addr;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign wb_go      = (state_q == S_WB) && (!out_vld_q || out_o.ready);
  assign key_wr     = cfg_we_i && ((cfg_idx_i == CFG_KEY_HIGH) || (cfg_idx_i == CFG_KEY_LOW));
  assign in_blk     = {in_i.block_in_high, in_i.block_in_low};
  assign prev_sel   = in_i.first_block ? {iv_high_q, iv_low_q} : {chain_high_q, chain_low_q};

  assign out_o.valid          = out_vld_q;
  assign out_o.block_out_high = res_q[127:64];
  assign out_o.block_out_low  = res_q[63:0];

  // Key schedule: window of the last four words, one new word per cycle.
  always_comb begin
    exp_t = win_q[31:0];
    exp_f = exp_t;
    if (exp_cnt_q[1:0] == 2'd0) begin
      exp_f = {SBOX[exp_t[23:16]], SBOX[exp_t[15:8]], SBOX[exp_t[7:0]], SBOX[exp_t[31:24]]}
              ^ {rcon_q, 24'h0};
    end
    exp_new = win_q[127:96] ^ exp_f;
    case (exp_cnt_q[1:0])
      2'd0:    exp_wdata = win_q[127:96];
      2'd1:    exp_wdata = win_q[95:64];
      2'd2:    exp_wdata = win_q[63:32];
      default: exp_wdata = win_q[31:0];
    endcase
    if (exp_cnt_q >= 6'd4) exp_wdata = exp_new;
  end

  assign rd_addr = {kidx_q, cnt_q[1:0]};

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXPAND) rk_mem[exp_cnt_q] <= exp_wdata;
    rk_q <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      rcon_q    <= 8'h01;
      exp_cnt_q <= '0;
    end else if (state_q == S_KLOAD) begin
      win_q     <= {key_high_q, key_low_q};
      rcon_q    <= 8'h01;
      exp_cnt_q <= '0;
    end else if (state_q == S_EXPAND) begin
      exp_cnt_q <= exp_cnt_q + 6'd1;
      if (exp_cnt_q >= 6'd4) begin
        win_q <= {win_q[95:0], exp_new};
        if (exp_cnt_q[1:0] == 2'd0) rcon_q <= xtime(rcon_q);
      end
    end
  end

  // Round sequencer.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q + 4'd1;
    kidx_d  = kidx_q;
    st_d    = st_q;
    case (state_q)
      S_KLOAD:  state_d = S_EXPAND;
      S_EXPAND: if (exp_cnt_q == LastWord) state_d = S_IDLE;
      S_IDLE: begin
        cnt_d = '0;
        if (in_acc) begin
          state_d = S_RUN;
          phase_d = P_ARK;
          kidx_d  = (in_i.opcode == OP_DECRYPT) ? LastRound : 4'd0;
          st_d    = in_blk ^ ((cbc_q && in_i.opcode == OP_ENCRYPT) ? prev_sel : '0);
        end
      end
      S_RUN: begin
        case (phase_q)
          P_ARK: begin
            if (cnt_q != 4'd0) st_d = {st_q[95:0], st_q[127:96] ^ rk_q};
            if (cnt_q == 4'd4) begin
              cnt_d = '0;
              if (dec_q == OP_ENCRYPT) begin
                if (kidx_q == LastRound) state_d = S_WB;
                else begin
                  kidx_d  = kidx_q + 4'd1;
                  phase_d = P_SUB;
                end
              end else begin
                if (kidx_q == 4'd0) state_d = S_WB;
                else if (kidx_q == LastRound) begin
                  kidx_d  = kidx_q - 4'd1;
                  phase_d = P_SR;
                end else phase_d = P_MIX;
              end
            end
          end
          P_SUB: begin
            st_d = {st_q[119:0], dec_q ? INV_SBOX[st_q[127:120]] : SBOX[st_q[127:120]]};
            if (cnt_q == 4'd15) begin
              cnt_d   = '0;
              phase_d = dec_q ? P_ARK : P_SR;
            end
          end
          P_SR: begin
            st_d  = shift_rows(st_q, dec_q);
            cnt_d = '0;
            if (dec_q) phase_d = P_SUB;
            else phase_d = (kidx_q == LastRound) ? P_ARK : P_MIX;
          end
          P_MIX: begin
            st_d = {st_q[95:0], mix_col(st_q[127:96], dec_q)};
            if (cnt_q == 4'd3) begin
              cnt_d = '0;
              if (dec_q) begin
                kidx_d  = kidx_q - 4'd1;
                phase_d = P_SR;
              end else phase_d = P_ARK;
            end
          end
          default: phase_d = P_ARK;
        endcase
      end
      S_WB:    if (wb_go) state_d = S_IDLE;
      default: state_d = S_KLOAD;
    endcase
    if (key_wr) state_d = S_KLOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_KLOAD;
      phase_q <= P_ARK;
      cnt_q   <= '0;
      kidx_q  <= '0;
      dec_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      kidx_q  <= kidx_d;
      if (in_acc) dec_q <= in_i.opcode;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (in_acc) prev_q <= prev_sel;
    if (wb_go) res_q <= (cbc_q && dec_q) ? (st_q ^ prev_q) : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (wb_go) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q   <= '0;
      key_low_q    <= '0;
      iv_high_q    <= '0;
      iv_low_q     <= '0;
      cbc_q        <= 1'b1;
      chain_high_q <= '0;
      chain_low_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_KEY_HIGH:   key_high_q <= cfg_data_i;
          CFG_KEY_LOW:    key_low_q  <= cfg_data_i;
          CFG_IV_HIGH:    iv_high_q  <= cfg_data_i;
          CFG_IV_LOW:     iv_low_q   <= cfg_data_i;
          CFG_CHAIN_MODE: cbc_q      <= cfg_data_i[0];
          default: ;
        endcase
      end
      // Decryption chains on the ciphertext going in, encryption on the one coming out.
      if (in_acc && cbc_q && in_i.opcode == OP_DECRYPT) begin
        chain_high_q <= in_i.block_in_high;
        chain_low_q  <= in_i.block_in_low;
      end else if (wb_go && cbc_q && dec_q == OP_ENCRYPT) begin
        chain_high_q <= st_q[127:64];
        chain_low_q  <= st_q[63:0];
      end
    end
  end

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !key_wr |=> state_q == S_RUN && phase_q == P_ARK && cnt_q == 4'd0)
    else $error("accepted beat did not start the round sequencer");

  a_kidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN |-> kidx_q <= LastRound)
    else $error("round key index out of range");

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("phase register not one-hot");

  a_expand_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXPAND && exp_cnt_q == LastWord && !key_wr |=> state_q == S_IDLE)
    else $error("key expansion did not finish after the last word");

  a_wb_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WB && out_vld_q && !out_o.ready && !key_wr |=> state_q == S_WB)
    else $error("write-back left while the output register was full");

endmodule

`default_nettype wire
